### hw/rtl/tga_rle_packet_decoder_core_assert.svh
// Assertion macros shared by the decoder RTL.
// Include by bare file name inside a module that has clk and rst_n.
`ifndef TGA_RLE_PACKET_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PACKET_DECODER_CORE_ASSERT_SVH

// Checked only outside reset.
`define TGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TGA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/tga_rle_pkg.sv
// Shared types, constants and helpers of the TGA RLE packet decoder.
// No dependencies.
package tga_rle_pkg;

  localparam int PIX_W       = 32;
  localparam int RUN_W       = 8;
  localparam int BPP_W       = 3;
  localparam int IMG_W       = 32;
  localparam int PROD_W      = 33;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [6:0] COUNT_MASK = 7'h7F;
  localparam int         REPEAT_BIT = 7;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;
  localparam logic [IMG_W-1:0] IMG_RESET = 32'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_BPP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG = 1'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [RUN_W-1:0] run_length;
    logic             from_repeat;
    logic             last;
    logic             overrun;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // Effective pixel size: 0 acts as 1, 5..7 act as 4.
  function automatic logic [BPP_W-1:0] pixel_size(input logic [BPP_W-1:0] b);
    logic [BPP_W-1:0] s;
    s = b;
    if (b == '0) s = 3'd1;
    else if (b > 3'd4) s = 3'd4;
    return s;
  endfunction

endpackage

### hw/rtl/tga_rle_front.sv
// Front end: config registers, header parse, pixel assembly, byte count, end check.
// Depends on tga_rle_pkg and the assertion macro header.
module tga_rle_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  tga_rle_pkg::in_item_t                 in_data,
  input  logic                                  q_full,
  input  logic                                  cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                  push,
  output tga_rle_pkg::out_item_t                push_data
);
  import tga_rle_pkg::*;

  `include "tga_rle_packet_decoder_core_assert.svh"

  logic [BPP_W-1:0]  bpp_r;
  logic [IMG_W-1:0]  img_r;
  logic              exp_hdr_r, exp_hdr_nxt;
  logic              rep_r, rep_nxt;
  logic [RUN_W-1:0]  left_r, left_nxt;
  logic [RUN_W-1:0]  runc_r, runc_nxt;
  logic [PIX_W-1:0]  asm_r, asm_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              done_r, done_nxt;

  logic              accept;
  logic              fs;
  logic [BPP_W-1:0]  bpp;
  logic [PIX_W-1:0]  asm_new;
  logic [10:0]       add_amt;
  logic [RUN_W-1:0]  left_dec;
  logic              pkt_end;

  assign accept = in_valid && !q_full;
  assign fs     = in_data.frame_start;
  assign bpp    = pixel_size(bpp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_RESET;
      img_r <= IMG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BPP: bpp_r <= cfg_wdata[BPP_W-1:0];
        CFG_IMG: img_r <= cfg_wdata[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exp_hdr_nxt = exp_hdr_r;
    rep_nxt     = rep_r;
    left_nxt    = left_r;
    runc_nxt    = runc_r;
    asm_nxt     = asm_r;
    idx_nxt     = idx_r;
    prod_nxt    = prod_r;
    done_nxt    = done_r;
    push        = 1'b0;
    asm_new     = asm_r | (PIX_W'(in_data.in_byte) << {idx_r, 3'b000});
    add_amt     = rep_r ? (11'(bpp) * 11'(runc_r)) : 11'(bpp);
    left_dec    = (left_r != '0) ? left_r - 8'd1 : left_r;
    pkt_end     = 1'b0;
    push_data   = '0;
    push_data.pixel_value = asm_new;
    push_data.run_length  = rep_r ? runc_r : 8'd1;
    push_data.from_repeat = rep_r;

    if (accept) begin
      if (fs) begin
        // new frame: clear, then this byte is a header
        prod_nxt = '0;
        done_nxt = 1'b0;
      end
      if (done_r && !fs) begin
        // image finished, drop bytes
      end else if (exp_hdr_r || fs) begin
        rep_nxt     = in_data.in_byte[REPEAT_BIT];
        left_nxt    = {1'b0, in_data.in_byte[6:0] & COUNT_MASK} + 8'd1;
        runc_nxt    = {1'b0, in_data.in_byte[6:0] & COUNT_MASK} + 8'd1;
        asm_nxt     = '0;
        idx_nxt     = '0;
        exp_hdr_nxt = 1'b0;
      end else if ({1'b0, idx_r} + 3'd1 < bpp) begin
        asm_nxt = asm_new;
        idx_nxt = idx_r + 2'd1;
      end else begin
        push     = 1'b1;
        prod_nxt = prod_r + PROD_W'(add_amt);
        if (rep_r) begin
          pkt_end = 1'b1;
        end else begin
          left_nxt = left_dec;
          pkt_end  = (left_dec == '0);
        end
        asm_nxt = '0;
        idx_nxt = '0;
        if (pkt_end) begin
          left_nxt    = '0;
          exp_hdr_nxt = 1'b1;
          if (prod_nxt >= {1'b0, img_r}) begin
            push_data.last    = 1'b1;
            push_data.overrun = (prod_nxt != {1'b0, img_r});
            done_nxt          = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r <= 1'b1;
      rep_r     <= 1'b0;
      left_r    <= '0;
      runc_r    <= '0;
      asm_r     <= '0;
      idx_r     <= '0;
      prod_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      exp_hdr_r <= exp_hdr_nxt;
      rep_r     <= rep_nxt;
      left_r    <= left_nxt;
      runc_r    <= runc_nxt;
      asm_r     <= asm_nxt;
      idx_r     <= idx_nxt;
      prod_r    <= prod_nxt;
      done_r    <= done_nxt;
    end
  end

  `TGA_ASSERT(a_over_needs_last, push |-> (push_data.last || !push_data.overrun), "overrun alone")
  `TGA_ASSERT(a_quiet_when_done, (done_r && !fs) |-> !push, "result after image end")
  `TGA_ASSERT(a_push_on_pixel, push |-> (accept && !exp_hdr_r && !fs), "result on a header")

endmodule

### hw/rtl/tga_rle_queue.sv
// Short result queue between front end and output stage.
// Depends on tga_rle_pkg and the assertion macro header.
module tga_rle_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tga_rle_pkg::out_item_t push_data,
  input  logic                   pop,
  output tga_rle_pkg::out_item_t pop_data,
  output tga_rle_pkg::q_stat_t   stat
);
  import tga_rle_pkg::*;

  `include "tga_rle_packet_decoder_core_assert.svh"

  out_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full      = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign pop_data       = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop)  rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `TGA_ASSERT(a_no_push_full, push |-> !stat.full, "push into full queue")
  `TGA_ASSERT(a_no_pop_empty, pop |-> stat.not_empty, "pop from empty queue")
  `TGA_ASSERT(a_count_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

### hw/rtl/tga_rle_back.sv
// Output stage: pops the queue into the result register, holds it under stall.
// Depends on tga_rle_pkg.
module tga_rle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tga_rle_pkg::q_stat_t   q_stat,
  input  tga_rle_pkg::out_item_t q_data,
  output logic                   pop,
  input  logic                   out_stall,
  output logic                   out_valid,
  output tga_rle_pkg::out_item_t out_data
);
  import tga_rle_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign pop       = q_stat.not_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= q_data;
  end

endmodule

### hw/rtl/tga_rle_packet_decoder_core.sv
// Top level of the TGA RLE packet decoder.
// Depends on tga_rle_pkg, tga_rle_front, tga_rle_queue, tga_rle_back.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one compressed stream byte per
//    beat, with frame_start set on the first byte of an image.
//  - Output channel (out_valid/out_stall/out_data): one pixel result per beat,
//    carrying pixel value, run length, repeat flag, last and overrun.
//  - Config port (cfg_we/cfg_index/cfg_wdata): index 0 bytes_per_pixel,
//    index 1 image_bytes. Write only while idle.
//  - Throughput: one input byte per cycle, sustained while in_stall is low; the
//    front end does the per-byte count update and end-of-image compare combinationally.
//  - Result path: a byte that completes a pixel has its result written to the
//    queue at its accepting edge, then moved to the output register (out_valid).
//  - Stall: a four-beat queue plus the output register absorb results; once the
//    queue is full in_stall rises. out_data holds steady while out_stall is high.
//  - Reset (rst_n low, synchronous): bytes_per_pixel=3, image_bytes=1, queue
//    and output emptied, decoder expects a header. No clearing pass.
//  - After last, bytes are dropped until a beat with frame_start arrives.
module tga_rle_packet_decoder_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tga_rle_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tga_rle_pkg::out_item_t             out_data,
  input  logic                               cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tga_rle_pkg::*;

  logic      push, pop;
  out_item_t push_data, q_data;
  q_stat_t   q_stat;

  // Stall straight from the registered queue count.
  assign in_stall = q_stat.full;

  tga_rle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_stat.full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data)
  );

  tga_rle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  tga_rle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
